// ===== design/awn_pkg.sv =====
// Package for the affine warp core: field widths, function and register codes,
// and the stage enable struct shared by the top level and the axis mapper.
// Depends on nothing.
package awn_pkg;

	localparam int COORD_W = 10;
	localparam int PIX_W   = 24;
	localparam int CFG_W   = 32;
	localparam int SIZE_W  = 9;
	localparam int FRAC_W  = 16;
	// 32-bit coefficient times 11-bit signed coordinate.
	localparam int PROD_W  = CFG_W + COORD_W + 1;
	// Two products, an offset and the half still fit with two guard bits.
	localparam int ACC_W   = PROD_W + 2;
	localparam int IDX_W   = ACC_W - FRAC_W;

	localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(32768);

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_WARP = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		REG_COEF_XU    = 3'd0,
		REG_COEF_XV    = 3'd1,
		REG_OFFSET_X   = 3'd2,
		REG_COEF_YU    = 3'd3,
		REG_COEF_YV    = 3'd4,
		REG_OFFSET_Y   = 3'd5,
		REG_SRC_WIDTH  = 3'd6,
		REG_SRC_HEIGHT = 3'd7
	} cfg_reg_t;

	// Load enables of the first three pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

// ===== design/affine_warp_nearest_core.sv =====
// Affine warp core with nearest-neighbour sampling. Depends on awn_pkg,
// awn_ram and awn_axis.
//
// Load items write a 24-bit pixel into the source frame. Warp items map the
// target point through the inverse matrix, add the half and truncate toward
// zero, and return the source pixel with a covered flag, or zero when the
// point falls outside the source image. The core takes one item per clock
// while the result side does not stall. A result passes through five register
// stages: three stages of multiply, accumulate and truncate, one stage of
// bounds check and frame address, and the output register fed by the
// registered read of the frame RAM. Loads write the RAM in the same stage in
// which warps read it, so items always see the frame in the order in which
// they arrived. Loads give no result. Back-pressure on the result side stalls
// only the stages that are full. The frame is not cleared at reset, and a
// pixel that was never loaded reads back as anything.
module affine_warp_nearest_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_addr,
	input  logic [awn_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [awn_pkg::COORD_W-1:0]   coord_x,
	input  logic [awn_pkg::COORD_W-1:0]   coord_y,
	input  logic [awn_pkg::PIX_W-1:0]     pixel_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [awn_pkg::PIX_W-1:0]     pixel_out,
	output logic                          covered
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam logic [awn_pkg::IDX_W-1:0] MAXW_L = awn_pkg::IDX_W'(MAX_WIDTH);
	localparam logic [awn_pkg::IDX_W-1:0] MAXH_L = awn_pkg::IDX_W'(MAX_HEIGHT);

	// Configuration registers.
	logic signed [awn_pkg::CFG_W-1:0] coef_xu_q, coef_xv_q, offset_x_q;
	logic signed [awn_pkg::CFG_W-1:0] coef_yu_q, coef_yv_q, offset_y_q;
	logic [awn_pkg::SIZE_W-1:0]       src_width_q, src_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xu_q    <= 32'sd65536;
			coef_xv_q    <= '0;
			offset_x_q   <= '0;
			coef_yu_q    <= '0;
			coef_yv_q    <= 32'sd65536;
			offset_y_q   <= '0;
			src_width_q  <= 9'd256;
			src_height_q <= 9'd256;
		end else if (cfg_we) begin
			case (awn_pkg::cfg_reg_t'(cfg_addr))
				awn_pkg::REG_COEF_XU:    coef_xu_q    <= cfg_data;
				awn_pkg::REG_COEF_XV:    coef_xv_q    <= cfg_data;
				awn_pkg::REG_OFFSET_X:   offset_x_q   <= cfg_data;
				awn_pkg::REG_COEF_YU:    coef_yu_q    <= cfg_data;
				awn_pkg::REG_COEF_YV:    coef_yv_q    <= cfg_data;
				awn_pkg::REG_OFFSET_Y:   offset_y_q   <= cfg_data;
				awn_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data[awn_pkg::SIZE_W-1:0];
				awn_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[awn_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids and per-stage ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	awn_pkg::stage_en_t en;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign en.s1    = rdy1;
	assign en.s2    = rdy2;
	assign en.s3    = rdy3;

	// Item payload carried beside the arithmetic.
	awn_pkg::func_t                 func_s1, func_s2, func_s3, func_s4;
	logic [awn_pkg::COORD_W-1:0]    cx_s1, cx_s2, cx_s3, cy_s1, cy_s2, cy_s3;
	logic [awn_pkg::PIX_W-1:0]      pix_s1, pix_s2, pix_s3, pix_s4;
	logic [AW-1:0]                  addr_s4;
	logic                           hit_s4;
	logic                           covered_s5;

	logic [awn_pkg::IDX_W-1:0]      ix_map_s3, iy_map_s3;
	logic [awn_pkg::IDX_W-1:0]      ix, iy, lim_x, lim_y, w_eff, h_eff;
	logic                           hit;
	logic [AW-1:0]                  addr;
	logic                           mem_we, mem_re;
	logic [awn_pkg::PIX_W-1:0]      mem_rdata;

	awn_axis u_axis_x (
		.clk    (clk),
		.en     (en),
		.coef_u (coef_xu_q),
		.coef_v (coef_xv_q),
		.offset (offset_x_q),
		.u      (coord_x),
		.v      (coord_y),
		.idx_s3 (ix_map_s3)
	);

	awn_axis u_axis_y (
		.clk    (clk),
		.en     (en),
		.coef_u (coef_yu_q),
		.coef_v (coef_yv_q),
		.offset (offset_y_q),
		.u      (coord_x),
		.v      (coord_y),
		.idx_s3 (iy_map_s3)
	);

	// The axis mappers take the coordinates straight from the input ports, so
	// their three registers run alongside stages one to three and the mapped
	// point is ready in stage three.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4 && (func_s4 == awn_pkg::FUNC_WARP);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			func_s1 <= awn_pkg::func_t'(func);
			cx_s1   <= coord_x;
			cy_s1   <= coord_y;
			pix_s1  <= pixel_in;
		end
		if (rdy2) begin
			func_s2 <= func_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			pix_s2  <= pix_s1;
		end
		if (rdy3) begin
			func_s3 <= func_s2;
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			pix_s3  <= pix_s2;
		end
		if (rdy4) begin
			func_s4 <= func_s3;
			pix_s4  <= pix_s3;
			addr_s4 <= addr;
			hit_s4  <= hit;
		end
		if (rdy5) begin
			covered_s5 <= v_s4 && hit_s4;
		end
	end

	// A size register above the frame dimension saturates to it.
	assign w_eff = (awn_pkg::IDX_W'(src_width_q) > MAXW_L) ? MAXW_L
		: awn_pkg::IDX_W'(src_width_q);
	assign h_eff = (awn_pkg::IDX_W'(src_height_q) > MAXH_L) ? MAXH_L
		: awn_pkg::IDX_W'(src_height_q);

	// Loads use their own coordinates against the frame dimensions, so both
	// kinds of item share one bounds check and one address path.
	always_comb begin
		if (func_s3 == awn_pkg::FUNC_LOAD) begin
			ix    = awn_pkg::IDX_W'(cx_s3);
			iy    = awn_pkg::IDX_W'(cy_s3);
			lim_x = MAXW_L;
			lim_y = MAXH_L;
		end else begin
			ix    = ix_map_s3;
			iy    = iy_map_s3;
			lim_x = w_eff;
			lim_y = h_eff;
		end
	end

	assign hit = !ix[awn_pkg::IDX_W-1] && (ix < lim_x)
		&& !iy[awn_pkg::IDX_W-1] && (iy < lim_y);
	assign addr = AW'(iy[RW-1:0]) * AW'(MAX_WIDTH) + AW'(ix[CW-1:0]);

	assign mem_we = v_s4 && rdy5 && (func_s4 == awn_pkg::FUNC_LOAD) && hit_s4;
	assign mem_re = v_s4 && rdy5 && (func_s4 == awn_pkg::FUNC_WARP) && hit_s4;

	awn_ram #(
		.WIDTH (awn_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_s4),
		.wdata (pix_s4),
		.re    (mem_re),
		.raddr (addr_s4),
		.rdata (mem_rdata)
	);

	assign out_valid = v_s5;
	assign covered   = covered_s5;
	assign pixel_out = covered_s5 ? mem_rdata : '0;

	a_uncovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !covered |-> pixel_out == '0)
		else $error("uncovered result carries a non-zero pixel");

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("frame written and read in the same cycle");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && rdy5 && (func_s4 == awn_pkg::FUNC_LOAD) |=> !out_valid)
		else $error("load item produced a result");

	a_read_hits_result: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> out_valid && covered)
		else $error("frame read not followed by a covered result");

endmodule

// ===== design/awn_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module awn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/awn_axis.sv =====
// One row of the inverse affine map: multiply, accumulate with the half, and
// truncate toward zero, over three pipeline stages. Depends on awn_pkg.
module awn_axis (
	input  logic                                  clk,
	input  awn_pkg::stage_en_t                    en,
	input  logic signed [awn_pkg::CFG_W-1:0]      coef_u,
	input  logic signed [awn_pkg::CFG_W-1:0]      coef_v,
	input  logic signed [awn_pkg::CFG_W-1:0]      offset,
	input  logic [awn_pkg::COORD_W-1:0]           u,
	input  logic [awn_pkg::COORD_W-1:0]           v,
	output logic [awn_pkg::IDX_W-1:0]             idx_s3
);

	logic signed [awn_pkg::PROD_W-1:0] prod_u;
	logic signed [awn_pkg::PROD_W-1:0] prod_v;
	logic signed [awn_pkg::PROD_W-1:0] prod_u_s1;
	logic signed [awn_pkg::PROD_W-1:0] prod_v_s1;
	logic signed [awn_pkg::ACC_W-1:0]  acc;
	logic signed [awn_pkg::ACC_W-1:0]  acc_s2;
	logic [awn_pkg::IDX_W-1:0]         floor_idx;
	logic                              round_up;

	assign prod_u = coef_u * $signed({1'b0, u});
	assign prod_v = coef_v * $signed({1'b0, v});

	assign acc = awn_pkg::ACC_W'(prod_u_s1) + awn_pkg::ACC_W'(prod_v_s1)
		+ awn_pkg::ACC_W'(offset) + awn_pkg::HALF_Q16;

	// The shift floors; a negative value with a fraction moves up by one so
	// that the result truncates toward zero.
	assign floor_idx = acc_s2[awn_pkg::ACC_W-1:awn_pkg::FRAC_W];
	assign round_up  = acc_s2[awn_pkg::ACC_W-1] && (acc_s2[awn_pkg::FRAC_W-1:0] != '0);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_u_s1 <= prod_u;
			prod_v_s1 <= prod_v;
		end
		if (en.s2) begin
			acc_s2 <= acc;
		end
		if (en.s3) begin
			idx_s3 <= floor_idx + awn_pkg::IDX_W'(round_up);
		end
	end

endmodule
